// ----- rtl/core/nrmc_pkg.sv -----
`default_nettype none

package nrmc_pkg;

  localparam int MAX_SENTENCE           = 256;
  localparam int MINUTE_FRACTION_DIGITS = 4;

  localparam int LEN_W   = 9;
  localparam int POS_W   = 3;
  localparam int CNT_W   = 3;
  localparam int FIELD_W = 4;
  localparam int FRAC_W  = 20;   // holds 10^6 - 1
  localparam int REM_W   = 27;   // minutes scaled, below 10^8
  localparam int DEG_W   = 11;   // whole degrees up to the limit
  localparam int DEGX_W  = 15;   // degrees times ten plus a digit
  localparam int NUM_W   = 27;   // scaled minutes numerator, below 10^8
  localparam int DMIC_W  = 31;   // degrees times 10^6
  localparam int Q_W     = 21;
  localparam int V_W     = 32;

  localparam logic [LEN_W-1:0]   LEN_SAT   = 9'd511;
  localparam logic [FIELD_W-1:0] FIELD_SAT = 4'd15;
  localparam logic [POS_W-1:0]   POS_SAT   = 3'd7;
  localparam logic [DEGX_W-1:0]  DEG_LIMIT = 15'd2000;

  localparam int POW_P     = 10 ** MINUTE_FRACTION_DIGITS;
  localparam int MIN_SCALE = 10 ** (6 - MINUTE_FRACTION_DIGITS);
  localparam int DIV_SHIFT = 33;
  localparam longint unsigned DIV_MUL = ((64'd1 << DIV_SHIFT) + 64'd59) / 64'd60;
  localparam int PROD_W    = NUM_W + 28;

  localparam logic [V_W-1:0] LAT_CAP   = 32'd100000000;
  localparam logic [V_W-1:0] LON_CAP   = 32'd1000000000;
  localparam logic [11:0]    YEAR_BASE = 12'd2000;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_V      = 8'h56;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FORMAT   = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_VOID     = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    KIND_RMC  = 3'd0,
    KIND_VTG  = 3'd1,
    KIND_GGA  = 3'd2,
    KIND_GSA  = 3'd3,
    KIND_GSV  = 3'd4,
    KIND_GLL  = 3'd5,
    KIND_NONE = 3'd6
  } kind_t;

  localparam int NUM_KINDS = 6;
  localparam logic [39:0] KIND_NAMES [NUM_KINDS] = '{
    40'h4750524D43,  // GPRMC
    40'h4750565447,  // GPVTG
    40'h4750474741,  // GPGGA
    40'h4750475341,  // GPGSA
    40'h4750475356,  // GPGSV
    40'h4750474C4C   // GPGLL
  };

  typedef struct packed {
    logic               clear;
    logic               int_push;
    logic               frac_push;
    logic               finish;
    logic [3:0]         digit;
    logic [CNT_W-1:0]   frac_count;
  } coord_ctl_t;

  typedef struct packed {
    logic               big;
    logic [DEG_W-1:0]   deg;
    logic [REM_W-1:0]   rem;
  } coord_state_t;

  typedef struct packed {
    logic        in_sentence;
    logic        has_comma;
    logic        header_len5;
    logic [39:0] header;
    logic        overlong;
    logic        void_seen;
    logic        star_seen;
    logic [7:0]  running_xor;
    logic [7:0]  star_sum;
    logic [23:0] time_bcd;
    logic [23:0] date_bcd;
  } snap_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  // padding factor for a fraction that has cnt digits so far
  function automatic logic [FRAC_W-1:0] pad_scale(input logic [CNT_W-1:0] cnt);
    int unsigned r;
    r = 1;
    for (int i = 0; i < MINUTE_FRACTION_DIGITS; i++) begin
      if (i >= int'(cnt)) r = r * 10;
    end
    return FRAC_W'(r);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nrmc_byte_if.sv -----
`default_nettype none

interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nrmc_result_if.sv -----
`default_nettype none

interface nrmc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  sentence_kind;
  logic [6:0]  utc_hour;
  logic [6:0]  utc_minute;
  logic [6:0]  utc_second;
  logic [6:0]  day_of_month;
  logic [6:0]  month_number;
  logic [11:0] full_year;
  logic [26:0] latitude_micro;
  logic [29:0] longitude_micro;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;

  modport source (output valid, output status, output sentence_kind, output utc_hour,
                  output utc_minute, output utc_second, output day_of_month,
                  output month_number, output full_year, output latitude_micro,
                  output longitude_micro, output computed_sum, output received_sum,
                  input ready);
  modport sink (input valid, input status, input sentence_kind, input utc_hour,
                input utc_minute, input utc_second, input day_of_month,
                input month_number, input full_year, input latitude_micro,
                input longitude_micro, input computed_sum, input received_sum,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nrmc_coord.sv -----
`default_nettype none

// One coordinate: whole degrees, last two integer digits, fraction digits.
module nrmc_coord (
  input  logic                  clk,
  input  logic                  rst,
  input  nrmc_pkg::coord_ctl_t  ctl,
  output nrmc_pkg::coord_state_t st
);

  logic                          big;
  logic [nrmc_pkg::DEG_W-1:0]    deg;
  logic [3:0]                    tens;
  logic [3:0]                    ones;
  logic [nrmc_pkg::FRAC_W-1:0]   frac;
  logic [nrmc_pkg::REM_W-1:0]    rem;

  logic [nrmc_pkg::DEGX_W-1:0]   deg_next;
  logic [6:0]                    min_whole;
  logic [nrmc_pkg::REM_W-1:0]    rem_next;

  always_comb begin
    deg_next  = nrmc_pkg::DEGX_W'(deg) * nrmc_pkg::DEGX_W'(10) + nrmc_pkg::DEGX_W'(tens);
    min_whole = 7'(tens) * 7'd10 + 7'(ones);
    rem_next  = nrmc_pkg::REM_W'(min_whole) * nrmc_pkg::REM_W'(nrmc_pkg::POW_P)
              + nrmc_pkg::REM_W'(frac)
              * nrmc_pkg::REM_W'(nrmc_pkg::pad_scale(ctl.frac_count));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      big  <= 1'b0;
      deg  <= '0;
      tens <= '0;
      ones <= '0;
      frac <= '0;
      rem  <= '0;
    end else begin
      if (ctl.int_push && !big) begin
        if (deg_next > nrmc_pkg::DEG_LIMIT) big <= 1'b1;
        else deg <= nrmc_pkg::DEG_W'(deg_next);
        tens <= ones;
        ones <= ctl.digit;
      end
      if (ctl.frac_push)
        frac <= nrmc_pkg::FRAC_W'(frac * nrmc_pkg::FRAC_W'(10) + nrmc_pkg::FRAC_W'(ctl.digit));
      if (ctl.finish) rem <= rem_next;
    end
  end

  assign st.big = big;
  assign st.deg = deg;
  assign st.rem = rem;

endmodule

`default_nettype wire

// ----- rtl/core/nrmc_scanner.sv -----
`default_nettype none

// Per-byte sentence state: framing, header, checksum, time, date, void flag.
module nrmc_scanner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            c,
  output logic                  fire,
  output nrmc_pkg::snap_t       snap,
  output nrmc_pkg::coord_ctl_t  lat_ctl,
  output nrmc_pkg::coord_ctl_t  lon_ctl
);

  logic                            in_sentence;
  logic [nrmc_pkg::LEN_W-1:0]      sentence_length;
  logic [nrmc_pkg::FIELD_W-1:0]    field_number;
  logic [7:0]                      running_xor;
  logic [39:0]                     header_chars;
  logic [2:0]                      header_len;
  logic [1:0]                      after_star_digits;
  logic                            star_seen;
  logic                            star_stop;
  logic [7:0]                      star_sum;
  logic [23:0]                     time_bcd;
  logic [23:0]                     date_bcd;
  logic [nrmc_pkg::CNT_W-1:0]      fraction_digit_count;
  logic [nrmc_pkg::POS_W-1:0]      field_pos;
  logic                            dot_seen;
  logic                            void_seen;
  logic                            overlong;

  logic [nrmc_pkg::LEN_W-1:0]      len_next;
  logic                            body;
  logic                            sep;
  logic                            coord_digit;
  logic                            frac_room;
  logic [4:0]                      hex;
  logic [4:0]                      nib_sh;
  logic [23:0]                     nib_mask;
  logic [23:0]                     nib_val;

  always_comb begin
    len_next    = (sentence_length < nrmc_pkg::LEN_SAT) ?
                  nrmc_pkg::LEN_W'(sentence_length + 1'b1) : sentence_length;
    fire        = take && (c == nrmc_pkg::CH_CR);
    body        = take && !fire && (sentence_length != '0) && in_sentence && !star_seen;
    sep         = (c == nrmc_pkg::CH_STAR) || (c == nrmc_pkg::CH_COMMA);
    coord_digit = body && !sep && nrmc_pkg::is_digit(c);
    frac_room   = fraction_digit_count < nrmc_pkg::CNT_W'(nrmc_pkg::MINUTE_FRACTION_DIGITS);
    hex         = nrmc_pkg::hex_val(c);
    nib_sh      = 5'(4'd5 - 4'(field_pos)) << 2;
    nib_mask    = ~(24'hF << nib_sh);
    nib_val     = nrmc_pkg::is_digit(c) ? (24'(c[3:0]) << nib_sh) : '0;

    lat_ctl.clear      = fire;
    lat_ctl.int_push   = coord_digit && (field_number == 4'd3) && !dot_seen;
    lat_ctl.frac_push  = coord_digit && (field_number == 4'd3) && dot_seen && frac_room;
    lat_ctl.finish     = body && sep && (field_number == 4'd3);
    lat_ctl.digit      = c[3:0];
    lat_ctl.frac_count = fraction_digit_count;

    lon_ctl.clear      = fire;
    lon_ctl.int_push   = coord_digit && (field_number == 4'd5) && !dot_seen;
    lon_ctl.frac_push  = coord_digit && (field_number == 4'd5) && dot_seen && frac_room;
    lon_ctl.finish     = body && sep && (field_number == 4'd5);
    lon_ctl.digit      = c[3:0];
    lon_ctl.frac_count = fraction_digit_count;
  end

  always_ff @(posedge clk) begin
    if (rst || fire) begin
      in_sentence          <= 1'b0;
      sentence_length      <= '0;
      field_number         <= '0;
      running_xor          <= '0;
      header_chars         <= '0;
      header_len           <= '0;
      after_star_digits    <= '0;
      star_seen            <= 1'b0;
      star_stop            <= 1'b0;
      star_sum             <= '0;
      time_bcd             <= '0;
      date_bcd             <= '0;
      fraction_digit_count <= '0;
      field_pos            <= '0;
      dot_seen             <= 1'b0;
      void_seen            <= 1'b0;
      overlong             <= 1'b0;
    end else if (take) begin
      if (sentence_length == '0) begin
        if (c != nrmc_pkg::CH_LF) begin
          in_sentence     <= (c == nrmc_pkg::CH_DOLLAR);
          sentence_length <= nrmc_pkg::LEN_W'(1);
        end
      end else begin
        sentence_length <= len_next;
        if (len_next >= nrmc_pkg::LEN_W'(nrmc_pkg::MAX_SENTENCE)) overlong <= 1'b1;
        if (in_sentence) begin
          if (star_seen) begin
            if (after_star_digits < 2'd2) begin
              after_star_digits <= after_star_digits + 1'b1;
              if (hex[4] && !star_stop) star_sum <= {star_sum[3:0], hex[3:0]};
              else star_stop <= 1'b1;
            end
          end else if (c == nrmc_pkg::CH_STAR) begin
            star_seen <= 1'b1;
          end else begin
            running_xor <= running_xor ^ c;
            if (c == nrmc_pkg::CH_COMMA) begin
              if (field_number < nrmc_pkg::FIELD_SAT) field_number <= field_number + 1'b1;
              field_pos            <= '0;
              dot_seen             <= 1'b0;
              fraction_digit_count <= '0;
            end else begin
              case (field_number)
                4'd0: begin
                  header_chars <= {header_chars[31:0], c};
                  if (header_len < 3'd6) header_len <= header_len + 1'b1;
                end
                4'd1: if (field_pos < 3'd6) time_bcd <= (time_bcd & nib_mask) | nib_val;
                4'd2: void_seen <= (field_pos == '0) && (c == nrmc_pkg::CH_V);
                4'd3, 4'd5: begin
                  if (nrmc_pkg::is_digit(c)) begin
                    if (dot_seen && frac_room)
                      fraction_digit_count <= fraction_digit_count + 1'b1;
                  end else if (c == nrmc_pkg::CH_DOT) begin
                    dot_seen <= 1'b1;
                  end
                end
                4'd9: if (field_pos < 3'd6) date_bcd <= (date_bcd & nib_mask) | nib_val;
                default: ;
              endcase
              if (field_pos < nrmc_pkg::POS_SAT) field_pos <= field_pos + 1'b1;
            end
          end
        end
      end
    end
  end

  assign snap.in_sentence = in_sentence;
  assign snap.has_comma   = field_number != '0;
  assign snap.header_len5 = header_len == 3'd5;
  assign snap.header      = header_chars;
  assign snap.overlong    = overlong;
  assign snap.void_seen   = void_seen;
  assign snap.star_seen   = star_seen;
  assign snap.running_xor = running_xor;
  assign snap.star_sum    = star_sum;
  assign snap.time_bcd    = time_bcd;
  assign snap.date_bcd    = date_bcd;

endmodule

`default_nettype wire

// ----- rtl/core/nrmc_emit.sv -----
`default_nettype none

// Verdict and field decode at carriage return, then the minutes scaling and
// the output register.
module nrmc_emit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  nrmc_pkg::snap_t         snap,
  input  nrmc_pkg::coord_state_t  lat,
  input  nrmc_pkg::coord_state_t  lon,
  output logic                    advance,
  nrmc_result_if.source           res
);

  function automatic logic [6:0] pair(input logic [23:0] bcd, input int idx);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = bcd[23 - 8 * idx -: 4];
    lo = bcd[19 - 8 * idx -: 4];
    return 7'(hi) * 7'd10 + 7'(lo);
  endfunction

  nrmc_pkg::kind_t   kind;
  nrmc_pkg::status_t st;
  logic              rmc_ok;

  always_comb begin
    kind = nrmc_pkg::KIND_NONE;
    // the header is only classified once a framed sentence has its first comma
    if (snap.header_len5 && snap.in_sentence && snap.has_comma) begin
      for (int i = nrmc_pkg::NUM_KINDS - 1; i >= 0; i--) begin
        if (snap.header == nrmc_pkg::KIND_NAMES[i]) kind = nrmc_pkg::kind_t'(3'(i));
      end
    end
    if (!snap.in_sentence || !snap.has_comma) st = nrmc_pkg::ST_FORMAT;
    else if (kind == nrmc_pkg::KIND_NONE) st = nrmc_pkg::ST_UNKNOWN;
    else st = nrmc_pkg::ST_OK;
    if (snap.overlong) st = nrmc_pkg::ST_TOO_LONG;
    if (st == nrmc_pkg::ST_OK && kind == nrmc_pkg::KIND_RMC) begin
      if (snap.void_seen) st = nrmc_pkg::ST_VOID;
      else if (!snap.star_seen || snap.running_xor != snap.star_sum)
        st = nrmc_pkg::ST_CHECKSUM;
    end
    rmc_ok = (st == nrmc_pkg::ST_OK) && (kind == nrmc_pkg::KIND_RMC);
  end

  // first stage
  logic                          s1_valid;
  nrmc_pkg::status_t             s1_status;
  nrmc_pkg::kind_t               s1_kind;
  logic                          s1_ok;
  logic [6:0]                    s1_hour, s1_min, s1_sec, s1_day, s1_month;
  logic [11:0]                   s1_year;
  logic [7:0]                    s1_xor, s1_sum;
  logic                          s1_lat_big, s1_lon_big;
  logic [nrmc_pkg::NUM_W-1:0]    s1_lat_num, s1_lon_num;
  logic [nrmc_pkg::DMIC_W-1:0]   s1_lat_deg, s1_lon_deg;

  assign advance = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= fire;
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      s1_status  <= st;
      s1_kind    <= kind;
      s1_ok      <= rmc_ok;
      s1_hour    <= pair(snap.time_bcd, 0);
      s1_min     <= pair(snap.time_bcd, 1);
      s1_sec     <= pair(snap.time_bcd, 2);
      s1_day     <= pair(snap.date_bcd, 0);
      s1_month   <= pair(snap.date_bcd, 1);
      s1_year    <= 12'(pair(snap.date_bcd, 2)) + nrmc_pkg::YEAR_BASE;
      s1_xor     <= snap.running_xor;
      s1_sum     <= snap.star_sum;
      s1_lat_big <= lat.big;
      s1_lon_big <= lon.big;
      s1_lat_num <= nrmc_pkg::NUM_W'(lat.rem) * nrmc_pkg::NUM_W'(nrmc_pkg::MIN_SCALE);
      s1_lon_num <= nrmc_pkg::NUM_W'(lon.rem) * nrmc_pkg::NUM_W'(nrmc_pkg::MIN_SCALE);
      s1_lat_deg <= nrmc_pkg::DMIC_W'(lat.deg) * nrmc_pkg::DMIC_W'(1000000);
      s1_lon_deg <= nrmc_pkg::DMIC_W'(lon.deg) * nrmc_pkg::DMIC_W'(1000000);
    end
  end

  // divide by sixty through a reciprocal
  logic [nrmc_pkg::PROD_W-1:0] lat_prod, lon_prod;
  logic [nrmc_pkg::V_W-1:0]    lat_v, lon_v, lat_out, lon_out;

  always_comb begin
    lat_prod = nrmc_pkg::PROD_W'(s1_lat_num) * nrmc_pkg::PROD_W'(nrmc_pkg::DIV_MUL);
    lon_prod = nrmc_pkg::PROD_W'(s1_lon_num) * nrmc_pkg::PROD_W'(nrmc_pkg::DIV_MUL);
    lat_v = nrmc_pkg::V_W'(s1_lat_deg)
          + nrmc_pkg::V_W'(nrmc_pkg::Q_W'(lat_prod >> nrmc_pkg::DIV_SHIFT));
    lon_v = nrmc_pkg::V_W'(s1_lon_deg)
          + nrmc_pkg::V_W'(nrmc_pkg::Q_W'(lon_prod >> nrmc_pkg::DIV_SHIFT));
    lat_out = (s1_lat_big || lat_v > nrmc_pkg::LAT_CAP) ? nrmc_pkg::LAT_CAP : lat_v;
    lon_out = (s1_lon_big || lon_v > nrmc_pkg::LON_CAP) ? nrmc_pkg::LON_CAP : lon_v;
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (advance) res.valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res.status          <= s1_status;
      res.sentence_kind   <= s1_kind;
      res.utc_hour        <= s1_ok ? s1_hour : '0;
      res.utc_minute      <= s1_ok ? s1_min : '0;
      res.utc_second      <= s1_ok ? s1_sec : '0;
      res.day_of_month    <= s1_ok ? s1_day : '0;
      res.month_number    <= s1_ok ? s1_month : '0;
      res.full_year       <= s1_ok ? s1_year : '0;
      res.latitude_micro  <= s1_ok ? 27'(lat_out) : '0;
      res.longitude_micro <= s1_ok ? 30'(lon_out) : '0;
      res.computed_sum    <= s1_xor;
      res.received_sum    <= s1_sum;
    end
  end

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !(res.status == nrmc_pkg::ST_OK && res.sentence_kind == nrmc_pkg::KIND_RMC)
    |-> res.latitude_micro == '0 && res.longitude_micro == '0 && res.full_year == '0)
    else $error("fields not cleared on a rejected sentence");

  a_sum_match: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == nrmc_pkg::ST_OK && res.sentence_kind == nrmc_pkg::KIND_RMC
    |-> res.computed_sum == res.received_sum)
    else $error("accepted RMC with checksum mismatch");

  a_unknown_not_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.sentence_kind == nrmc_pkg::KIND_NONE |-> res.status != nrmc_pkg::ST_OK)
    else $error("unrecognised header reported as ok");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("first stage dropped while stalled");

  a_lat_cap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> 32'(res.latitude_micro) <= nrmc_pkg::LAT_CAP)
    else $error("latitude above cap");

endmodule

`default_nettype wire

// ----- rtl/core/nmea_rmc_sentence_parser.sv -----
// NMEA 0183 sentence parser with RMC field extraction.
// rx: one received character per request (valid/ready, payload rx_byte).
// res: one result request per carriage return: status, sentence kind, UTC
//   time, date, latitude and longitude in micro-degrees, and both checksums.
// A sentence starts at its first byte ('$' expected); a line feed in first
// place is skipped. Bytes after '*' give the received checksum (two hex
// digits at most). Bytes of an overlong sentence are still parsed.
// Throughput: one byte per cycle, sustained, while res is taken.
// Pipeline: the decode is registered into the first stage when the carriage
// return is taken; the minutes scaling (reciprocal divide by sixty) then
// feeds the output register, from which the result is valid.
// Stall: while res.valid is high and res.ready low the whole pipeline holds
// and rx.ready is low; no request is lost or repeated.
// Reset (rst, synchronous, active high) clears the sentence state and drops
// any result in flight; rx.ready is high in the first cycle after reset.
`default_nettype none

module nmea_rmc_sentence_parser (
  input  logic           clk,
  input  logic           rst,
  nrmc_byte_if.sink      rx,
  nrmc_result_if.source  res
);

  logic                    advance;
  logic                    take;
  logic                    fire;
  nrmc_pkg::snap_t         snap;
  nrmc_pkg::coord_ctl_t    lat_ctl, lon_ctl;
  nrmc_pkg::coord_state_t  lat_st, lon_st;

  // bytes are taken only when the result side can move
  assign rx.ready = advance;
  assign take     = rx.valid && rx.ready;

  nrmc_scanner u_scanner (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .c       (rx.rx_byte),
    .fire    (fire),
    .snap    (snap),
    .lat_ctl (lat_ctl),
    .lon_ctl (lon_ctl)
  );

  nrmc_coord u_lat (
    .clk (clk),
    .rst (rst),
    .ctl (lat_ctl),
    .st  (lat_st)
  );

  nrmc_coord u_lon (
    .clk (clk),
    .rst (rst),
    .ctl (lon_ctl),
    .st  (lon_st)
  );

  nrmc_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .snap    (snap),
    .lat     (lat_st),
    .lon     (lon_st),
    .advance (advance),
    .res     (res)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_nmea_rmc_sentence_parser.sv -----
`default_nettype none

module tb_nmea_rmc_sentence_parser;
  import nrmc_pkg::*;

  // Upper bound on cycles with no request moving on either side.
  // The long receiver hold-off (HOLD_CYCLES) is far shorter, so this leaves ample margin.
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;   // receiver hold-off that fills the pipe
  localparam longint unsigned ACC_SAT = 64'd1000000000000000;

  typedef struct {
    status_t     status;
    kind_t       kind;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
    logic [26:0] lat;
    logic [29:0] lon;
    logic [7:0]  csum;
    logic [7:0]  rsum;
  } fix_report_t;

  // Directed sentences; st is the status read straight off the spec, or -1.
  typedef struct {
    string txt;
    int    st;
  } line_row_t;

  logic clk;
  logic rst;

  nrmc_byte_if   rx_if ();
  nrmc_result_if res_if ();

  nmea_rmc_sentence_parser dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if.sink),
    .res (res_if.source)
  );

  // ---------------------------------------------------------------------------
  // Stimulus and expectation stores
  // ---------------------------------------------------------------------------
  logic [7:0]  char_q[$];      // bytes still to be offered
  int          typed_st_q[$];  // one entry per carriage return queued
  fix_report_t report_q[$];    // reports the parser owes us, oldest first

  int n_bytes_taken;
  int n_reports;
  int n_rmc_ok;
  int n_errors;
  int idle_run;
  bit hold_rx;                 // long hold-off on the result side

  // ---------------------------------------------------------------------------
  // Sentence tracker: own copy of the parser state
  // ---------------------------------------------------------------------------
  bit              t_in;
  int              t_len;
  int              t_field;
  logic [7:0]      t_xor;
  logic [39:0]     t_hdr;
  int              t_hdr_len;
  int              t_star_digits;
  logic [7:0]      t_star_sum;
  logic [23:0]     t_time;
  logic [23:0]     t_date;
  longint unsigned t_lat;
  longint unsigned t_lon;
  int              t_frac;
  bit              t_void;
  bit              t_long;
  bit              t_star;
  bit              t_hex_stop;
  int              t_pos;
  bit              t_dot;

  task automatic clear_tracker();
    t_in = 0; t_len = 0; t_field = 0; t_xor = '0; t_hdr = '0; t_hdr_len = 0;
    t_star_digits = 0; t_star_sum = '0; t_time = '0; t_date = '0;
    t_lat = 0; t_lon = 0; t_frac = 0; t_void = 0; t_long = 0; t_star = 0;
    t_hex_stop = 0; t_pos = 0; t_dot = 0;
  endtask

  function automatic longint unsigned shift_digit(longint unsigned acc, int d);
    longint unsigned v;
    v = acc * 10 + longint'(d);
    return (v > ACC_SAT) ? ACC_SAT : v;
  endfunction

  task automatic coord_digit(inout longint unsigned acc, input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      if (!t_dot) begin
        acc = shift_digit(acc, c - "0");
      end else if (t_frac < MINUTE_FRACTION_DIGITS) begin
        acc = shift_digit(acc, c - "0");
        t_frac++;
      end
    end else if (c == CH_DOT) begin
      t_dot = 1;
    end
  endtask

  // pad the fraction of a coordinate field out to the fixed digit count
  task automatic close_field();
    while ((t_field == 3 || t_field == 5) && t_frac < MINUTE_FRACTION_DIGITS) begin
      if (t_field == 3) t_lat = shift_digit(t_lat, 0);
      else t_lon = shift_digit(t_lon, 0);
      t_frac++;
    end
  endtask

  function automatic logic [23:0] put_nibble(logic [23:0] bcd, int pos, logic [7:0] c);
    int sh;
    if (pos >= 6) return bcd;
    sh = 4 * (5 - pos);
    bcd &= ~(24'hF << sh);
    if (c >= "0" && c <= "9") bcd |= 24'(c - "0") << sh;
    return bcd;
  endfunction

  function automatic int digit_pair(logic [23:0] bcd, int idx);
    int sh;
    sh = 4 * (4 - 2 * idx);
    return ((bcd >> (sh + 4)) & 4'hF) * 10 + ((bcd >> sh) & 4'hF);
  endfunction

  // ddmm.mmmm (fixed fraction digits) to micro-degrees, saturating at cap
  function automatic longint unsigned micro_deg(longint unsigned acc, longint unsigned cap);
    longint unsigned scale, deg, rem, v;
    scale = 1;
    for (int i = 0; i < MINUTE_FRACTION_DIGITS; i++) scale *= 10;
    deg = acc / (100 * scale);
    rem = acc % (100 * scale);
    if (deg > 2000) return cap;
    v = deg * 1000000 + (rem * 1000000) / (60 * scale);
    return (v > cap) ? cap : v;
  endfunction

  function automatic fix_report_t build_report();
    fix_report_t r;
    int          st;
    int          kd;
    r.hour = '0; r.minute = '0; r.second = '0; r.day = '0; r.month = '0;
    r.year = '0; r.lat = '0; r.lon = '0;
    st = ST_OK;
    kd = KIND_NONE;
    if (!t_in || t_field == 0) begin
      st = ST_FORMAT;
    end else begin
      if (t_hdr_len == 5)
        for (int k = NUM_KINDS - 1; k >= 0; k--)
          if (KIND_NAMES[k] == t_hdr) kd = k;
      if (kd == KIND_NONE) st = ST_UNKNOWN;
    end
    if (t_long) st = ST_TOO_LONG;
    if (st == ST_OK && kd == KIND_RMC) begin
      if (t_void) st = ST_VOID;
      else if (!t_star || t_xor != t_star_sum) st = ST_CHECKSUM;
    end
    if (st == ST_OK && kd == KIND_RMC) begin
      r.hour   = 7'(digit_pair(t_time, 0));
      r.minute = 7'(digit_pair(t_time, 1));
      r.second = 7'(digit_pair(t_time, 2));
      r.day    = 7'(digit_pair(t_date, 0));
      r.month  = 7'(digit_pair(t_date, 1));
      r.year   = 12'(digit_pair(t_date, 2)) + YEAR_BASE;
      r.lat    = 27'(micro_deg(t_lat, LAT_CAP));
      r.lon    = 30'(micro_deg(t_lon, LON_CAP));
    end
    r.status = status_t'(st);
    r.kind   = kind_t'(kd);
    r.csum   = t_xor;
    r.rsum   = t_star_sum;
    return r;
  endfunction

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    return 5'd0;
  endfunction

  // advance the tracker by one received byte; a report is queued at CR
  task automatic track_byte(input logic [7:0] c);
    logic [4:0] hv;
    if (c == CH_CR) begin
      report_q.push_back(build_report());
      clear_tracker();
      return;
    end
    if (t_len == 0) begin
      if (c == CH_LF) return;
      t_in = (c == CH_DOLLAR);
      t_len = 1;
      return;
    end
    if (t_len < 511) t_len++;
    if (t_len >= MAX_SENTENCE) t_long = 1;
    if (!t_in) return;
    if (t_star) begin
      if (t_star_digits < 2) begin
        hv = hex_nibble(c);
        t_star_digits++;
        if (hv[4] && !t_hex_stop) t_star_sum = {t_star_sum[3:0], hv[3:0]};
        else t_hex_stop = 1;
      end
      return;
    end
    if (c == CH_STAR) begin
      t_star = 1;
      close_field();
      return;
    end
    t_xor ^= c;
    if (c == CH_COMMA) begin
      close_field();
      if (t_field < 15) t_field++;
      t_pos = 0; t_dot = 0; t_frac = 0;
      return;
    end
    case (t_field)
      0: begin
        t_hdr = {t_hdr[31:0], c};
        if (t_hdr_len < 6) t_hdr_len++;
      end
      1: t_time = put_nibble(t_time, t_pos, c);
      2: t_void = (t_pos == 0 && c == CH_V);
      3: coord_digit(t_lat, c);
      5: coord_digit(t_lon, c);
      9: t_date = put_nibble(t_date, t_pos, c);
      default: ;
    endcase
    if (t_pos < 255) t_pos++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  logic [7:0] body_xor;

  task automatic queue_byte(input logic [7:0] b, input int st = -1);
    char_q.push_back(b);
    if (b == CH_CR) typed_st_q.push_back(st);
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // body text between '$' and '*', with the checksum gathered on the way
  task automatic queue_body(input string s);
    for (int i = 0; i < s.len(); i++) begin
      body_xor ^= s[i];
      queue_byte(s[i]);
    end
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  // coordinate field: mostly ddmm.f..., sometimes empty, huge or odd
  function automatic string rand_coord(int max_deg);
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return "";
    if (sel < 10) return rand_digits($urandom_range(12, 20));
    if (sel < 15) return {rand_digits($urandom_range(1, 6)), ".", rand_digits(3), ".7"};
    return $sformatf("%0d%02d.%s", $urandom_range(max_deg), $urandom_range(99),
                     rand_digits($urandom_range(0, 7)));
  endfunction

  task automatic queue_sentence();
    int    sel;
    string hdr, stat, body;
    int    pad;
    body_xor = '0;
    if ($urandom_range(99) < 20) queue_byte(CH_LF);
    queue_byte(CH_DOLLAR);
    sel = $urandom_range(99);
    if (sel < 70) hdr = "GPRMC";
    else if (sel < 85) begin
      case ($urandom_range(4))
        0: hdr = "GPVTG";
        1: hdr = "GPGGA";
        2: hdr = "GPGSA";
        3: hdr = "GPGSV";
        default: hdr = "GPGLL";
      endcase
    end else if (sel < 92) hdr = "GPRMX";
    else if (sel < 96) hdr = "XGPRMC";
    else hdr = "GPRM";
    sel = $urandom_range(99);
    stat = (sel < 70) ? "A" : (sel < 85) ? "V" : (sel < 93) ? "VA" : "";
    body = $sformatf("%s,%s.%s,%s,%s,%s,%s,%s,%0d.%0d,%0d.%0d,%s,,",
                     hdr, rand_digits($urandom_range(4, 7)), rand_digits(2), stat,
                     rand_coord(90), ($urandom_range(1)) ? "N" : "S",
                     rand_coord(180), ($urandom_range(1)) ? "E" : "W",
                     $urandom_range(99), $urandom_range(9),
                     $urandom_range(359), $urandom_range(9),
                     rand_digits($urandom_range(5, 7)));
    queue_body(body);
    // an occasional sentence padded up to or past the length bound
    if ($urandom_range(99) < 3) begin
      pad = $urandom_range(MAX_SENTENCE - 100, MAX_SENTENCE + 40);
      for (int i = 0; i < pad; i++) queue_body("9");
    end
    sel = $urandom_range(99);
    if (sel < 75) queue_body("");
    if (sel < 65) begin
      queue_byte(CH_STAR);
      queue_str($sformatf("%02X", body_xor));
    end else if (sel < 70) begin
      queue_byte(CH_STAR);
      queue_str($sformatf("%02x", body_xor));
    end else if (sel < 80) begin
      queue_byte(CH_STAR);
      queue_str($sformatf("%02X", $urandom_range(255)));
    end else if (sel < 90) begin
      queue_byte(CH_STAR);
      queue_str((sel & 1) ? "G" : {$sformatf("%1X", body_xor[7:4]), "Z"});
    end
    // else: no star at all
    queue_byte(CH_CR);
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)));
    queue_byte(CH_CR);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, idling pattern
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // phases by bytes taken: none, sender idle 60%, receiver stall 60%, both 10%, none
  function automatic int phase_now();
    return (n_bytes_taken / 250) % 5;
  endfunction

  function automatic bit sender_idles();
    case (phase_now())
      1: return $urandom_range(99) < 60;
      3: return $urandom_range(99) < 10;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (phase_now())
      2: return $urandom_range(99) < 60;
      3: return $urandom_range(99) < 10;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender: holds each request until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (char_q.size() > 0 && !sender_idles()) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= char_q.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result side ready, with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= !hold_rx && !receiver_stalls();
  end

  // one long hold-off once traffic is flowing: the parser must back up
  initial begin
    hold_rx = 1'b0;
    wait (n_bytes_taken >= 400);
    @(posedge clk);
    hold_rx = 1'b1;
    for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
    hold_rx = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fix_report_t want, got;
    int          typed;
    bit          bad;
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        n_bytes_taken++;
        track_byte(rx_if.rx_byte);
      end
      if (res_if.valid && res_if.ready) begin
        got.status = status_t'(res_if.status);
        got.kind   = kind_t'(res_if.sentence_kind);
        got.hour   = res_if.utc_hour;
        got.minute = res_if.utc_minute;
        got.second = res_if.utc_second;
        got.day    = res_if.day_of_month;
        got.month  = res_if.month_number;
        got.year   = res_if.full_year;
        got.lat    = res_if.latitude_micro;
        got.lon    = res_if.longitude_micro;
        got.csum   = res_if.computed_sum;
        got.rsum   = res_if.received_sum;
        n_reports++;
        if (report_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected report: %p", got);
        end else begin
          want  = report_q.pop_front();
          typed = (typed_st_q.size() > 0) ? typed_st_q.pop_front() : -1;
          bad = (got.status !== want.status) || (got.kind !== want.kind) ||
                (got.hour !== want.hour) || (got.minute !== want.minute) ||
                (got.second !== want.second) || (got.day !== want.day) ||
                (got.month !== want.month) || (got.year !== want.year) ||
                (got.lat !== want.lat) || (got.lon !== want.lon) ||
                (got.csum !== want.csum) || (got.rsum !== want.rsum) ||
                (typed >= 0 && got.status !== 3'(typed));
          if (want.status == ST_OK && want.kind == KIND_RMC) n_rmc_ok++;
          if (bad) begin
            n_errors++;
            if (n_errors <= 10)
              $display("report %0d mismatch (spec status %0d)\n  exp %p\n  got %p",
                       n_reports, typed, want, got);
          end
        end
      end
    end
  end

  // watchdog: cycles in which nothing moves on either side
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  line_row_t directed [] = '{
    '{"\015", ST_FORMAT},                 // empty line
    '{"\n\015", ST_FORMAT},               // leading LF then empty
    '{"$\015", ST_FORMAT},                // dollar but no comma
    '{"X,\015", ST_FORMAT},               // no dollar
    '{"$GPVTG,\015", ST_OK},              // known non-RMC type
    '{"$GPXYZ,\015", ST_UNKNOWN},
    '{"$GPRMC,,V,\015", ST_VOID}
  };

  initial begin
    int n_sent;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    n_bytes_taken = 0; n_reports = 0; n_rmc_ok = 0; n_errors = 0; idle_run = 0;
    clear_tracker();

    foreach (directed[i])
      for (int j = 0; j < directed[i].txt.len(); j++)
        queue_byte(directed[i].txt[j], directed[i].st);
    // byte extremes inside a header
    queue_byte(CH_DOLLAR); queue_byte(8'h00); queue_byte(8'hFF); queue_byte(CH_COMMA);
    queue_byte(CH_CR, ST_UNKNOWN);

    // random part: mostly well-formed sentences, some noise
    n_sent = 0;
    while (char_q.size() < 1750 || n_sent < 40) begin
      if ($urandom_range(99) < 12) queue_noise();
      else queue_sentence();
      n_sent++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (char_q.size() > 0 || rx_if.valid) @(posedge clk);
    while (report_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bytes parsed into %0d reports, %0d good RMC fixes, across idle phases",
             n_bytes_taken, n_reports, n_rmc_ok);
    if (n_errors == 0 && report_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad reports", n_errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/nrmc_pkg.sv
rtl/core/nrmc_byte_if.sv
rtl/core/nrmc_result_if.sv
rtl/core/nrmc_coord.sv
rtl/core/nrmc_scanner.sv
rtl/core/nrmc_emit.sv
rtl/core/nmea_rmc_sentence_parser.sv
tb/sv/tb_nmea_rmc_sentence_parser.sv
